// ===== sv/gbepc_pkg.sv =====
package gbepc_pkg;

   localparam int DATA_W  = 30;
   localparam int START_W = 6;
   localparam int MOVE_W  = 7;
   localparam int GRID_W  = 7;
   localparam int CMP_W   = 12;

   typedef logic [DATA_W-1:0] count_type;

   localparam count_type MODULUS = 30'd1000000007;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   function automatic count_type add_mod(input count_type a, input count_type b);
      logic [DATA_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, MODULUS}) begin
         sum = sum - {1'b0, MODULUS};
      end
      return sum[DATA_W-1:0];
   endfunction

endpackage

// ===== sv/gbepc_ram.sv =====
module gbepc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gbepc_csr.sv =====
module gbepc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output logic [gbepc_pkg::GRID_W-1:0] grid_rows,
   output logic [gbepc_pkg::GRID_W-1:0] grid_cols
);

   import gbepc_pkg::*;

   logic [GRID_W-1:0] rows_ff, rows_in;
   logic [GRID_W-1:0] cols_ff, cols_in;
   logic              wr_fire;

   assign wr_fire = psel && penable && pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_fire) begin
         unique case (paddr[2])
            REG_ROWS: rows_in = pwdata[GRID_W-1:0];
            REG_COLS: cols_in = pwdata[GRID_W-1:0];
            default:  rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= GRID_W'(1);
         cols_ff <= GRID_W'(1);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ROWS: prdata = {{(32-GRID_W){1'b0}}, rows_ff};
         REG_COLS: prdata = {{(32-GRID_W){1'b0}}, cols_ff};
         default:  prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign grid_rows = rows_ff;
   assign grid_cols = cols_ff;

endmodule

// ===== sv/gbepc_stencil.sv =====
module gbepc_stencil #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RSW = $clog2(MAX_ROWS + 1),
   localparam int CSW = $clog2(MAX_COLS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 in_valid,
   input  logic [RSW-1:0]       in_row,
   input  logic [CW-1:0]        in_col,
   input  gbepc_pkg::count_type in_value,
   input  logic [RSW-1:0]       rows_eff,
   input  logic [CSW-1:0]       cols_eff,
   output logic                 wr_en,
   output logic [RW+CW-1:0]     wr_addr,
   output gbepc_pkg::count_type wr_data,
   output gbepc_pkg::count_type exit_total
);

   import gbepc_pkg::*;

   localparam int LINE = 2 * MAX_COLS + 1;

   // window taps, stride of one full row
   count_type line_ff [LINE];

   logic           c_valid_ff;
   logic [RSW-1:0] c_row_ff;
   logic [CW-1:0]  c_col_ff;

   logic [RSW-1:0] ctr_row;
   logic           ctr_ok;
   logic           at_top, at_bottom, at_left, at_right;
   count_type      center, nb_up, nb_down, nb_left, nb_right;
   count_type      sum_ud_in, sum_lr_in;

   logic             d_valid_ff;
   logic [RW+CW-1:0] d_addr_ff;
   count_type        sum_ud_ff, sum_lr_ff;

   count_type exit_ff [4];
   count_type exit_in [4];
   count_type pair_ff [2];
   count_type total_ff;

   always_ff @(posedge clock) begin
      if (in_valid) begin
         line_ff[0] <= in_value;
         for (int i = 1; i < LINE; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
      c_row_ff <= in_row;
      c_col_ff <= in_col;
   end

   // center cell sits one row behind the incoming item
   assign ctr_row   = c_row_ff - RSW'(1);
   assign ctr_ok    = c_valid_ff && (c_row_ff != '0)
                      && (CMP_W'(ctr_row) < CMP_W'(rows_eff))
                      && (CMP_W'(c_col_ff) < CMP_W'(cols_eff));
   assign at_top    = (ctr_row == '0);
   assign at_bottom = (CMP_W'(c_row_ff) >= CMP_W'(rows_eff));
   assign at_left   = (c_col_ff == '0);
   assign at_right  = ((CMP_W'(c_col_ff) + CMP_W'(1)) >= CMP_W'(cols_eff));

   assign center   = line_ff[MAX_COLS];
   assign nb_up    = at_top    ? '0 : line_ff[2*MAX_COLS];
   assign nb_down  = at_bottom ? '0 : line_ff[0];
   assign nb_left  = at_left   ? '0 : line_ff[MAX_COLS+1];
   assign nb_right = at_right  ? '0 : line_ff[MAX_COLS-1];

   assign sum_ud_in = add_mod(nb_up, nb_down);
   assign sum_lr_in = add_mod(nb_left, nb_right);

   always_comb begin
      exit_in[0] = (ctr_ok && at_top)    ? add_mod(exit_ff[0], center) : exit_ff[0];
      exit_in[1] = (ctr_ok && at_bottom) ? add_mod(exit_ff[1], center) : exit_ff[1];
      exit_in[2] = (ctr_ok && at_left)   ? add_mod(exit_ff[2], center) : exit_ff[2];
      exit_in[3] = (ctr_ok && at_right)  ? add_mod(exit_ff[3], center) : exit_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= in_valid;
         d_valid_ff <= ctr_ok;
      end
   end

   always_ff @(posedge clock) begin
      d_addr_ff <= {ctr_row[RW-1:0], c_col_ff};
      sum_ud_ff <= sum_ud_in;
      sum_lr_ff <= sum_lr_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < 4; i++) begin
            exit_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            exit_ff[i] <= exit_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pair_ff[0] <= add_mod(exit_ff[0], exit_ff[1]);
      pair_ff[1] <= add_mod(exit_ff[2], exit_ff[3]);
      total_ff   <= add_mod(pair_ff[0], pair_ff[1]);
   end

   assign wr_en      = d_valid_ff;
   assign wr_addr    = d_addr_ff;
   assign wr_data    = add_mod(sum_ud_ff, sum_lr_ff);
   assign exit_total = total_ff;

endmodule

// ===== sv/grid_boundary_exit_path_counter.sv =====
// Completion: a start outside the grid or zero moves gives its result in the cycle after accept;
//   otherwise each move runs one scan pass and a drain, then ST_SUM1 and ST_SUM2 give the result.
// Throughput: one item at a time, busy high until its result for items that need passes;
//   each pass reads one cell per cycle from the count memory, row stride MAX_COLS, plus one flush row.
// Reset: synchronous, active high; clears control and the grid registers to 1x1.
//   Count memories are not cleared; the first pass seeds the start cell directly.
module grid_boundary_exit_path_counter #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_MOVES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gbepc_pkg::START_W-1:0] req_start_row,
   input  logic [gbepc_pkg::START_W-1:0] req_start_col,
   input  logic [gbepc_pkg::MOVE_W-1:0]  req_move_limit,
   output logic                          rsp_strobe,
   output logic [gbepc_pkg::DATA_W-1:0]  rsp_path_count,
   output logic                          rsp_bad_start,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   import gbepc_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RSW   = $clog2(MAX_ROWS + 1);
   localparam int CSW   = $clog2(MAX_COLS + 1);
   localparam int KW    = $clog2(MAX_MOVES + 1);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SUM1  = 3'd3;
   localparam logic [2:0] ST_SUM2  = 3'd4;

   localparam logic [1:0] DRAIN_LAST = 2'd2;

   logic [GRID_W-1:0] grid_rows, grid_cols;

   logic [2:0]         state_ff, state_in;
   logic [RSW-1:0]     rows_ff, rows_in, rows_sat;
   logic [CSW-1:0]     cols_ff, cols_in, cols_sat;
   logic [KW-1:0]      moves_ff, moves_in, moves_sat;
   logic [KW-1:0]      pass_ff, pass_in;
   logic [START_W-1:0] srow_ff, srow_in, scol_ff, scol_in;
   logic [RSW-1:0]     row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [1:0]         drain_ff, drain_in;

   logic           accept, start_bad, issue, clear;
   logic           b_valid_ff;
   logic [RSW-1:0] b_row_ff;
   logic [CW-1:0]  b_col_ff;
   logic           b_seed_ff;

   logic      rsp_fire_ff, rsp_fire_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_bad_ff, rsp_bad_in;

   logic [AW-1:0] rd_addr, wr_addr;
   count_type     rdata_a, rdata_b, in_value, wr_data, exit_total;
   logic          wr_en;

   gbepc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .grid_rows (grid_rows),
      .grid_cols (grid_cols)
   );

   assign rows_sat  = (CMP_W'(grid_rows) > CMP_W'(MAX_ROWS)) ? RSW'(MAX_ROWS) : RSW'(grid_rows);
   assign cols_sat  = (CMP_W'(grid_cols) > CMP_W'(MAX_COLS)) ? CSW'(MAX_COLS) : CSW'(grid_cols);
   assign moves_sat = (CMP_W'(req_move_limit) > CMP_W'(MAX_MOVES))
                      ? KW'(MAX_MOVES) : KW'(req_move_limit);
   assign start_bad = (CMP_W'(req_start_row) >= CMP_W'(rows_sat))
                      || (CMP_W'(req_start_col) >= CMP_W'(cols_sat));
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      moves_in     = moves_ff;
      pass_in      = pass_ff;
      srow_in      = srow_ff;
      scol_in      = scol_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      drain_in     = drain_ff;
      issue        = 1'b0;
      clear        = 1'b0;
      rsp_fire_in  = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rows_in  = rows_sat;
               cols_in  = cols_sat;
               moves_in = moves_sat;
               srow_in  = req_start_row;
               scol_in  = req_start_col;
               row_in   = '0;
               col_in   = '0;
               pass_in  = '0;
               clear    = 1'b1;
               if (start_bad || (moves_sat == '0)) begin
                  rsp_fire_in  = 1'b1;
                  rsp_count_in = '0;
                  rsp_bad_in   = start_bad;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue = 1'b1;
            if (col_ff == CW'(MAX_COLS - 1)) begin
               col_in = '0;
               if (row_ff == rows_ff) begin
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end else begin
                  row_in = row_ff + RSW'(1);
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               pass_in = pass_ff + KW'(1);
               row_in  = '0;
               col_in  = '0;
               if (pass_in == moves_ff) begin
                  state_in = ST_SUM1;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         ST_SUM1: begin
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            state_in     = ST_IDLE;
            rsp_fire_in  = 1'b1;
            rsp_count_in = exit_total;
            rsp_bad_in   = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pass_ff     <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         drain_ff    <= '0;
         b_valid_ff  <= 1'b0;
         rsp_fire_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         drain_ff    <= drain_in;
         b_valid_ff  <= issue;
         rsp_fire_ff <= rsp_fire_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff      <= rows_in;
      cols_ff      <= cols_in;
      moves_ff     <= moves_in;
      srow_ff      <= srow_in;
      scol_ff      <= scol_in;
      b_row_ff     <= row_ff;
      b_col_ff     <= col_ff;
      b_seed_ff    <= (CMP_W'(row_ff) == CMP_W'(srow_ff))
                      && (CMP_W'(col_ff) == CMP_W'(scol_ff));
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rd_addr = {row_ff[RW-1:0], col_ff};

   // pass 0 starts from the seed; later passes read what the previous pass wrote
   assign in_value = (pass_ff == '0) ? count_type'(b_seed_ff)
                                     : (pass_ff[0] ? rdata_b : rdata_a);

   gbepc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_grid_a (
      .clock   (clock),
      .wr_en   (wr_en && pass_ff[0]),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_a)
   );

   gbepc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_grid_b (
      .clock   (clock),
      .wr_en   (wr_en && !pass_ff[0]),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_b)
   );

   gbepc_stencil #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_stencil (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .in_valid   (b_valid_ff),
      .in_row     (b_row_ff),
      .in_col     (b_col_ff),
      .in_value   (in_value),
      .rows_eff   (rows_ff),
      .cols_eff   (cols_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .exit_total (exit_total)
   );

   assign rsp_strobe     = rsp_fire_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_bad_start  = rsp_bad_ff;

`ifndef ASSERT_OFF
   a_bad_start_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && start_bad) |=> (rsp_strobe && rsp_bad_start))
      else $error("bad start item did not complete in one cycle");

   a_bad_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_bad_start) |-> (rsp_path_count == '0))
      else $error("bad start item with nonzero count");

   a_count_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_path_count < MODULUS))
      else $error("path count not reduced");

   a_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("count memory write outside a pass");
`endif

endmodule
